// ----- hw/rtl/lexeme_scanner_defines.svh -----
// assertion macros for the lexeme scanner
`ifndef LEXEME_SCANNER_DEFINES_SVH
`define LEXEME_SCANNER_DEFINES_SVH

`ifndef ASSERT_OFF
`define LXS_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define LXS_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define LXS_ASSERT_IMP(lbl, ante, cons, msg)
`define LXS_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ----- hw/rtl/lxs_pkg.sv -----
// types, codes and character classes for the lexeme scanner
`timescale 1ns / 1ps
`default_nettype none

package lxs_pkg;

   // input item kinds
   localparam logic [1:0] KIND_BYTE = 2'd0;
   localparam logic [1:0] KIND_LINE = 2'd1;
   localparam logic [1:0] KIND_END  = 2'd2;

   // token types
   localparam logic [3:0] TOK_END      = 4'd0;
   localparam logic [3:0] TOK_OPERATOR = 4'd1;
   localparam logic [3:0] TOK_PUNCT    = 4'd2;
   localparam logic [3:0] TOK_IDENT    = 4'd3;
   localparam logic [3:0] TOK_DECIMAL  = 4'd4;
   localparam logic [3:0] TOK_STRING   = 4'd5;
   localparam logic [3:0] TOK_BAD_CHAR = 4'd6;
   localparam logic [3:0] TOK_BAD_IDENT = 4'd7;
   localparam logic [3:0] TOK_BAD_LIT  = 4'd8;
   localparam logic [3:0] TOK_UNTERM   = 4'd9;

   typedef struct packed {
      logic [7:0]  token_char;
      logic        char_valid;
      logic        last_of_token;
      logic [3:0]  token_type;
      logic [15:0] token_line;
      logic [9:0]  token_column;
   } rsp_type;

   function automatic rsp_type make_rsp(input logic [7:0] ch, input logic cv,
                                        input logic last, input logic [3:0] typ,
                                        input logic [15:0] line, input logic [9:0] col);
      rsp_type r;
      r.token_char    = ch;
      r.char_valid    = cv;
      r.last_of_token = last;
      r.token_type    = typ;
      r.token_line    = line;
      r.token_column  = col;
      return r;
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return c inside {8'h20, 8'h09, 8'h0b, 8'h0c};
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c inside {[8'h30:8'h39]};
   endfunction

   // upper-cased identifier character, zero if c is not one
   function automatic logic [7:0] ident_of(input logic [7:0] c);
      logic [7:0] r;
      r = 8'h00;
      if (c inside {[8'h61:8'h7a]}) begin
         r = c - 8'd32;
      end else if (c inside {[8'h41:8'h5a], [8'h30:8'h39], 8'h24, 8'h5f}) begin
         r = c;
      end
      return r;
   endfunction

   function automatic logic is_op(input logic [7:0] c);
      return c inside {8'h2e, 8'h5e, 8'h2a, 8'h2f, 8'h2b, 8'h2d, 8'h3d};
   endfunction

   function automatic logic is_punct(input logic [7:0] c);
      return c inside {8'h2c, 8'h3b, 8'h3a, 8'h28, 8'h29, 8'h5b, 8'h5d, 8'h3c,
                       8'h3e, 8'h25};
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/lexeme_scanner.sv -----
// lexeme scanner: byte stream in, token characters and token ends out
//
// Input channel (req_): one item per transfer, a text byte, a line end or a
// stream end. Output channel (rsp_): one result per transfer, either a token
// character or a closing marker carrying the token type, line and column.
// Both channels transfer when valid is high and stall is low.
// One byte is held back as lookahead, so a byte's results come out with the
// item that follows it. The scan step is done in the cycle the item is
// taken and its results (zero to three) land in a four-entry result queue;
// the first can be offered on rsp_ from the cycle after the transfer.
// Items are taken one per cycle while the queue holds at most one result,
// so a stream yielding at most one result per item runs at one item per
// cycle unless the receiver stalls; more results per item hold the input.
// The queue drain (one result per unstalled cycle) sets the sustained rate.
// When the receiver stalls, results stay in the queue and req_stall rises
// once two or more are waiting.
// Synchronous reset returns the scanner to its start state with an empty
// queue; a stream end does the same to the scan state after its end token.
`timescale 1ns / 1ps
`default_nettype none
`include "lexeme_scanner_defines.svh"

module lexeme_scanner #(
   parameter int LINE_SIZE        = 1024,
   parameter int LINE_NUMBER_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [1:0]  req_kind,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic        req_sign_ok,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [7:0]  rsp_token_char,
   output      logic        rsp_char_valid,
   output      logic        rsp_last_of_token,
   output      logic [3:0]  rsp_token_type,
   output      logic [15:0] rsp_token_line,
   output      logic [9:0]  rsp_token_column
);
   import lxs_pkg::*;

   localparam int CW = $clog2(LINE_SIZE + 1);
   localparam int LW = LINE_NUMBER_BITS;
   localparam logic [CW-1:0] LS = CW'(LINE_SIZE);

   localparam logic [2:0] S_INIT    = 3'd0;
   localparam logic [2:0] S_EMB     = 3'd1;
   localparam logic [2:0] S_DEC     = 3'd2;
   localparam logic [2:0] S_STR     = 3'd3;
   localparam logic [2:0] S_IDN     = 3'd4;
   localparam logic [2:0] S_ERRWAIT = 3'd5;
   localparam logic [2:0] S_ERRSKIP = 3'd6;
   localparam logic [2:0] S_LCOMM   = 3'd7;

   localparam logic [7:0] CH_QUOTE   = 8'h27;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_BANG    = 8'h21;
   localparam logic [7:0] CH_PLUS    = 8'h2b;
   localparam logic [7:0] CH_MINUS   = 8'h2d;

   // scanner state
   logic [2:0]    st_ff, st_in;
   logic [7:0]    la_byte_ff, la_byte_in;
   logic          la_valid_ff, la_valid_in;
   logic [LW-1:0] line_ff, line_in;
   logic [CW-1:0] col_ff, col_in;
   logic [CW-1:0] tlen_ff, tlen_in;
   logic [3:0]    ptype_ff, ptype_in;
   logic [LW-1:0] sline_ff, sline_in;
   logic [9:0]    scol_ff, scol_in;

   // result queue
   rsp_type       fifo_ff [4];
   logic [1:0]    wr_ptr_ff, wr_ptr_in;
   logic [1:0]    rd_ptr_ff, rd_ptr_in;
   logic [2:0]    cnt_ff, cnt_in;

   logic          accept;
   logic          pop;
   rsp_type       res [4];
   logic [2:0]    n;
   logic [1:0]    nout;
   logic          scan_en;
   logic          nb;
   logic          used;
   logic          do_init;
   logic          do_eol;
   logic [7:0]    c;
   logic [7:0]    nx;
   logic [7:0]    chx;
   logic [CW-1:0] colx;

   assign accept    = req_valid && !req_stall;
   assign pop       = (cnt_ff != 3'd0) && !rsp_stall;
   assign req_stall = cnt_ff > 3'd1;

   always_comb begin
      st_in       = st_ff;
      la_byte_in  = la_byte_ff;
      la_valid_in = la_valid_ff;
      line_in     = line_ff;
      col_in      = col_ff;
      tlen_in     = tlen_ff;
      ptype_in    = ptype_ff;
      sline_in    = sline_ff;
      scol_in     = scol_ff;
      res         = '{default: '0};
      n           = 3'd0;
      scan_en     = 1'b0;
      nb          = 1'b0;
      used        = 1'b0;
      do_init     = 1'b0;
      do_eol      = 1'b0;
      c           = la_byte_ff;
      nx          = req_in_byte;
      chx         = 8'h00;
      colx        = CW'(col_ff - 1'b1);

      if (accept) begin
         case (req_kind)
            KIND_BYTE: begin
               if (col_ff < LS) begin
                  col_in = CW'(col_ff + 1'b1);
                  if (la_valid_ff) begin
                     scan_en = 1'b1;
                     nb      = 1'b1;
                  end
               end
            end
            KIND_LINE, KIND_END: begin
               do_eol = 1'b1;
               if (la_valid_ff) begin
                  scan_en     = 1'b1;
                  la_valid_in = 1'b0;
               end
            end
            default: ;
         endcase
      end

      // scan the held byte against the incoming one
      if (scan_en) begin
         case (st_in)
            S_INIT: do_init = 1'b1;
            S_EMB: begin
               if (c == CH_RPAREN && nb && nx == CH_PERCENT) begin
                  st_in = S_INIT;
                  used  = 1'b1;
               end
            end
            S_IDN: begin
               chx = ident_of(c);
               if (chx != 8'h00) begin
                  if (tlen_in < LS) begin
                     tlen_in = CW'(tlen_in + 1'b1);
                     res[n[1:0]] = make_rsp(chx, 1'b1, 1'b0, TOK_END, 16'(sline_in), scol_in);
                     n = 3'(n + 1'b1);
                  end
               end else if (c == CH_PERCENT && nb && ident_of(nx) != 8'h00) begin
                  ptype_in = TOK_BAD_IDENT;
                  st_in    = S_ERRWAIT;
               end else begin
                  res[n[1:0]] = make_rsp(8'h00, 1'b0, 1'b1, TOK_IDENT, 16'(sline_in), scol_in);
                  n       = 3'(n + 1'b1);
                  tlen_in = '0;
                  st_in   = S_INIT;
                  do_init = 1'b1;
               end
            end
            S_DEC: begin
               if (is_digit(c)) begin
                  if (tlen_in < LS) begin
                     tlen_in = CW'(tlen_in + 1'b1);
                     res[n[1:0]] = make_rsp(c, 1'b1, 1'b0, TOK_END, 16'(sline_in), scol_in);
                     n = 3'(n + 1'b1);
                  end
               end else if (ident_of(c) != 8'h00 ||
                            (c == CH_PERCENT && nb && ident_of(nx) != 8'h00)) begin
                  ptype_in = TOK_BAD_LIT;
                  st_in    = S_ERRWAIT;
               end else begin
                  res[n[1:0]] = make_rsp(8'h00, 1'b0, 1'b1, TOK_DECIMAL, 16'(sline_in),
                                         scol_in);
                  n       = 3'(n + 1'b1);
                  tlen_in = '0;
                  st_in   = S_INIT;
                  do_init = 1'b1;
               end
            end
            S_STR: begin
               if (c == CH_QUOTE) begin
                  if (nb && nx == CH_QUOTE) begin
                     // doubled quote stands for one quote character
                     if (tlen_in < LS) begin
                        tlen_in = CW'(tlen_in + 1'b1);
                        res[n[1:0]] = make_rsp(c, 1'b1, 1'b0, TOK_END, 16'(sline_in),
                                               scol_in);
                        n    = 3'(n + 1'b1);
                        used = 1'b1;
                     end
                  end else begin
                     res[n[1:0]] = make_rsp(8'h00, 1'b0, 1'b1, TOK_STRING, 16'(sline_in),
                                            scol_in);
                     n       = 3'(n + 1'b1);
                     tlen_in = '0;
                     st_in   = S_INIT;
                  end
               end else if (tlen_in < LS) begin
                  tlen_in = CW'(tlen_in + 1'b1);
                  res[n[1:0]] = make_rsp(c, 1'b1, 1'b0, TOK_END, 16'(sline_in), scol_in);
                  n = 3'(n + 1'b1);
               end
            end
            S_ERRWAIT: begin
               res[n[1:0]] = make_rsp(8'h00, 1'b0, 1'b1, ptype_in, 16'(sline_in), scol_in);
               n       = 3'(n + 1'b1);
               tlen_in = '0;
               st_in   = S_ERRSKIP;
            end
            S_ERRSKIP: begin
               if (is_blank(c)) begin
                  st_in = S_INIT;
               end
            end
            default: ;
         endcase

         // start of a new lexeme
         if (do_init) begin
            if (is_blank(c)) begin
               st_in = S_INIT;
            end else if (c == CH_BANG) begin
               st_in = S_LCOMM;
            end else if (c == CH_PERCENT && nb && nx == CH_LPAREN) begin
               st_in = S_EMB;
               used  = 1'b1;
            end else begin
               sline_in = LW'(line_ff + 1'b1);
               scol_in  = 10'(colx);
               tlen_in  = '0;
               if (c == CH_QUOTE) begin
                  st_in = S_STR;
               end else if (is_digit(c) ||
                            (req_sign_ok && (c == CH_PLUS || c == CH_MINUS) && nb &&
                             is_digit(nx))) begin
                  tlen_in = CW'(1);
                  res[n[1:0]] = make_rsp(c, 1'b1, 1'b0, TOK_END, 16'(sline_in), scol_in);
                  n     = 3'(n + 1'b1);
                  st_in = S_DEC;
               end else if (ident_of(c) != 8'h00 ||
                            (c == CH_PERCENT && nb && ident_of(nx) != 8'h00)) begin
                  chx     = (c == CH_PERCENT) ? c : ident_of(c);
                  tlen_in = CW'(1);
                  res[n[1:0]] = make_rsp(chx, 1'b1, 1'b0, TOK_END, 16'(sline_in), scol_in);
                  n     = 3'(n + 1'b1);
                  st_in = S_IDN;
               end else if (is_op(c)) begin
                  res[n[1:0]] = make_rsp(c, 1'b1, 1'b1, TOK_OPERATOR, 16'(sline_in),
                                         scol_in);
                  n = 3'(n + 1'b1);
               end else if (is_punct(c)) begin
                  res[n[1:0]] = make_rsp(c, 1'b1, 1'b1, TOK_PUNCT, 16'(sline_in), scol_in);
                  n = 3'(n + 1'b1);
               end else begin
                  ptype_in = TOK_BAD_CHAR;
                  st_in    = S_ERRWAIT;
               end
            end
         end
      end

      // lookahead update for a byte that was not dropped
      if (accept && req_kind == KIND_BYTE && col_ff < LS) begin
         if (used) begin
            la_valid_in = 1'b0;
         end else begin
            la_byte_in  = req_in_byte;
            la_valid_in = 1'b1;
         end
      end

      // line end or stream end closes what is open
      if (do_eol) begin
         case (st_in)
            S_DEC: begin
               res[n[1:0]] = make_rsp(8'h00, 1'b0, 1'b1, TOK_DECIMAL, 16'(sline_in), scol_in);
               n       = 3'(n + 1'b1);
               tlen_in = '0;
               st_in   = S_INIT;
            end
            S_IDN: begin
               res[n[1:0]] = make_rsp(8'h00, 1'b0, 1'b1, TOK_IDENT, 16'(sline_in), scol_in);
               n       = 3'(n + 1'b1);
               tlen_in = '0;
               st_in   = S_INIT;
            end
            S_STR: begin
               res[n[1:0]] = make_rsp(8'h00, 1'b0, 1'b1, TOK_UNTERM, 16'(sline_in), scol_in);
               n       = 3'(n + 1'b1);
               tlen_in = '0;
               st_in   = S_INIT;
            end
            S_LCOMM, S_ERRSKIP: st_in = S_INIT;
            default: ;
         endcase
         if (req_kind == KIND_LINE) begin
            line_in = LW'(line_ff + 1'b1);
            col_in  = '0;
         end else begin
            res[n[1:0]] = make_rsp(8'h00, 1'b0, 1'b1, TOK_END,
                                   16'(LW'(line_ff + LW'(col_ff != '0))), 10'd0);
            n           = 3'(n + 1'b1);
            st_in       = S_INIT;
            la_byte_in  = 8'h00;
            la_valid_in = 1'b0;
            line_in     = '0;
            col_in      = '0;
            tlen_in     = '0;
            ptype_in    = TOK_END;
            sline_in    = '0;
            scol_in     = '0;
         end
      end

      // at most three results leave per item
      nout = (n > 3'd3) ? 2'd3 : n[1:0];
   end

   always_comb begin
      wr_ptr_in = accept ? 2'(wr_ptr_ff + nout) : wr_ptr_ff;
      rd_ptr_in = pop ? 2'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      cnt_in    = 3'(cnt_ff + (accept ? {1'b0, nout} : 3'd0) - {2'b00, pop});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff       <= S_INIT;
         la_byte_ff  <= 8'h00;
         la_valid_ff <= 1'b0;
         line_ff     <= '0;
         col_ff      <= '0;
         tlen_ff     <= '0;
         ptype_ff    <= TOK_END;
         sline_ff    <= '0;
         scol_ff     <= '0;
         wr_ptr_ff   <= 2'd0;
         rd_ptr_ff   <= 2'd0;
         cnt_ff      <= 3'd0;
      end else begin
         st_ff       <= st_in;
         la_byte_ff  <= la_byte_in;
         la_valid_ff <= la_valid_in;
         line_ff     <= line_in;
         col_ff      <= col_in;
         tlen_ff     <= tlen_in;
         ptype_ff    <= ptype_in;
         sline_ff    <= sline_in;
         scol_ff     <= scol_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         cnt_ff      <= cnt_in;
      end
   end

   // queue storage, no reset needed
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (accept && 2'(i) < nout) begin
            fifo_ff[2'(wr_ptr_ff + 2'(i))] <= res[2'(i)];
         end
      end
   end

   assign rsp_valid         = cnt_ff != 3'd0;
   assign rsp_token_char    = fifo_ff[rd_ptr_ff].token_char;
   assign rsp_char_valid    = fifo_ff[rd_ptr_ff].char_valid;
   assign rsp_last_of_token = fifo_ff[rd_ptr_ff].last_of_token;
   assign rsp_token_type    = fifo_ff[rd_ptr_ff].token_type;
   assign rsp_token_line    = fifo_ff[rd_ptr_ff].token_line;
   assign rsp_token_column  = fifo_ff[rd_ptr_ff].token_column;

   `LXS_ASSERT_IMP(a_queue_room, accept, cnt_ff <= 3'd1, "transfer taken without queue room")
   `LXS_ASSERT_IMP(a_queue_bound, 1'b1, cnt_ff <= 3'd4, "result queue overflow")
   `LXS_ASSERT_IMP(a_la_col, la_valid_ff, col_ff != '0, "lookahead held at column zero")
   `LXS_ASSERT_NXT(a_end_clears, accept && req_kind == KIND_END,
                   !la_valid_ff && st_ff == S_INIT && col_ff == '0,
                   "stream end did not clear scanner")
   `LXS_ASSERT_NXT(a_drain, pop && !accept, cnt_ff == 3'($past(cnt_ff) - 1'b1),
                   "queue count wrong after drain")

endmodule

`default_nettype wire
